### hw/rtl/console_serial_line_registers_core_assert.svh
// Assertion macros used by the console serial line checker.
`ifndef CONSOLE_SERIAL_LINE_REGISTERS_CORE_ASSERT_SVH
`define CONSOLE_SERIAL_LINE_REGISTERS_CORE_ASSERT_SVH

// Clocked check, masked while reset is asserted.
`define CSLR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("%m: check failed");

// Clocked check that also holds through reset.
`define CSLR_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("%m: check failed");

`endif

### hw/rtl/cslr_pkg.sv
// Types and constants of the console serial line register block.
package cslr_pkg;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_RECV  = 2'd2,
        MODE_TICK  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_RXS = 2'd0,
        REG_RXB = 2'd1,
        REG_TXS = 2'd2,
        REG_TXB = 2'd3
    } t_sel;

    typedef struct packed {
        t_mode       mode;
        logic [2:0]  reg_offset;
        logic [15:0] write_data;
        logic [7:0]  rx_char;
    } t_in_word;

    typedef struct packed {
        logic [15:0] read_data;
        logic        tx_valid;
        logic [6:0]  tx_char;
        logic        rx_irq;
        logic        tx_irq;
        logic        bad_access;
    } t_out_word;

    localparam logic [7:0] TX_DELAY_RESET = 8'd32;
    localparam logic [7:0] TX_DELAY_MAX   = 8'd254;
    localparam logic [7:0] TX_WAIT_MAX    = 8'd255;
    localparam logic [7:0] CH_STAR        = 8'd42;
    localparam logic [7:0] CH_STAR_MAP    = 8'd4;
    localparam logic [7:0] CH_DC3         = 8'd19;
    localparam logic [7:0] CH_DC3_MAP     = 8'o034;
    localparam int         BIT_DONE       = 7;
    localparam int         BIT_IE         = 6;

endpackage

### hw/rtl/console_serial_line_registers_core.sv
// Top level of the console serial line register block.
//
// Input channel: i_in_valid / o_in_stall carry one word per cycle: a bus read,
// a bus write, a received character or a transmit tick. A word is taken at a
// rising edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall return exactly one result word for
// every input word, in order.
// Path: a taken word passes through the input register, then the register update
// feeding the result register, which drives o_out_valid.
// Throughput: one word per cycle while i_out_stall is low, set by the single
// update pass between the input register and the result register.
// Stall: while i_out_stall holds a waiting result, the result register and the
// register file hold; the input register still fills, and o_in_stall rises
// only once both stages are occupied.
// Configuration: i_cfg_we writes i_cfg_data into the transmit delay register;
// it takes effect on the next tick processed.
// Reset (i_rst_n low, synchronous): both stages empty, status words return to
// receiver idle and transmitter ready, delay returns to 32 ticks.
module console_serial_line_registers_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cslr_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cslr_pkg::t_out_word o_out_data,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_data
);
    import cslr_pkg::*;

    logic       r_in_valid;
    t_in_word   r_in;
    logic       r_out_valid;
    t_out_word  r_out;
    logic [7:0] r_tx_delay;

    logic       advance;
    logic       fire;
    logic       in_take;
    t_out_word  result;

    // Advance the second stage whenever the result register is free or drains.
    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    cslr_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_word     (r_in),
        .i_tx_delay (r_tx_delay),
        .o_result   (result)
    );

    // Input register: refill when empty or when its word moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || advance) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    // Result register: hold while stalled, drop valid once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_delay <= TX_DELAY_RESET;
        end else if (i_cfg_we) begin
            r_tx_delay <= i_cfg_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### hw/rtl/cslr_regs.sv
// Register file and update logic for one word of the console serial line.
module cslr_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  cslr_pkg::t_in_word  i_word,
    input  logic [7:0]          i_tx_delay,
    output cslr_pkg::t_out_word o_result
);
    import cslr_pkg::*;

    // Only the done/ready and interrupt enable bits of the status words can be set.
    logic       r_rx_done, n_rx_done;
    logic       r_rx_ie,   n_rx_ie;
    logic       r_tx_rdy,  n_tx_rdy;
    logic       r_tx_ie,   n_tx_ie;
    logic [7:0] r_rx_buf,  n_rx_buf;
    logic [7:0] r_tx_buf,  n_tx_buf;
    logic [7:0] r_tx_wait, n_tx_wait;

    t_sel       sel;
    logic [7:0] lim;
    logic [7:0] wait_inc;

    assign sel      = t_sel'(i_word.reg_offset[2:1]);
    assign lim      = (i_tx_delay > TX_DELAY_MAX) ? TX_DELAY_MAX : i_tx_delay;
    assign wait_inc = (r_tx_wait < TX_WAIT_MAX) ? (r_tx_wait + 8'd1) : r_tx_wait;

    always_comb begin
        n_rx_done = r_rx_done;
        n_rx_ie   = r_rx_ie;
        n_tx_rdy  = r_tx_rdy;
        n_tx_ie   = r_tx_ie;
        n_rx_buf  = r_rx_buf;
        n_tx_buf  = r_tx_buf;
        n_tx_wait = r_tx_wait;
        o_result  = '0;
        unique case (i_word.mode)
            MODE_READ: begin
                unique case (sel)
                    REG_RXS: begin
                        o_result.read_data[BIT_DONE] = r_rx_done;
                        o_result.read_data[BIT_IE]   = r_rx_ie;
                    end
                    REG_RXB: begin
                        if (r_rx_done) begin
                            n_rx_done          = 1'b0;
                            o_result.read_data = {8'd0, r_rx_buf};
                        end
                    end
                    REG_TXS: begin
                        o_result.read_data[BIT_DONE] = r_tx_rdy;
                        o_result.read_data[BIT_IE]   = r_tx_ie;
                    end
                    REG_TXB: begin
                    end
                    default: begin
                    end
                endcase
            end
            MODE_WRITE: begin
                unique case (sel)
                    REG_RXS: n_rx_ie = i_word.write_data[BIT_IE];
                    REG_RXB: o_result.bad_access = 1'b1;
                    REG_TXS: n_tx_ie = i_word.write_data[BIT_IE];
                    REG_TXB: begin
                        n_tx_buf  = i_word.write_data[7:0];
                        n_tx_rdy  = 1'b0;
                        n_tx_wait = '0;
                    end
                    default: begin
                    end
                endcase
            end
            MODE_RECV: begin
                priority if (i_word.rx_char == CH_STAR) begin
                    n_rx_buf = CH_STAR_MAP;
                end else if (i_word.rx_char == CH_DC3) begin
                    n_rx_buf = CH_DC3_MAP;
                end else begin
                    n_rx_buf = i_word.rx_char;
                end
                n_rx_done       = 1'b1;
                o_result.rx_irq = r_rx_ie;
            end
            MODE_TICK: begin
                if (!r_tx_rdy) begin
                    n_tx_wait = wait_inc;
                    if (wait_inc > lim) begin
                        o_result.tx_valid = 1'b1;
                        o_result.tx_char  = r_tx_buf[6:0];
                        o_result.tx_irq   = r_tx_ie;
                        n_tx_rdy          = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_done <= 1'b0;
            r_rx_ie   <= 1'b0;
            r_tx_rdy  <= 1'b1;
            r_tx_ie   <= 1'b0;
            r_rx_buf  <= '0;
            r_tx_buf  <= '0;
            r_tx_wait <= '0;
        end else if (i_fire) begin
            r_rx_done <= n_rx_done;
            r_rx_ie   <= n_rx_ie;
            r_tx_rdy  <= n_tx_rdy;
            r_tx_ie   <= n_tx_ie;
            r_rx_buf  <= n_rx_buf;
            r_tx_buf  <= n_tx_buf;
            r_tx_wait <= n_tx_wait;
        end
    end

endmodule

### hw/rtl/cslr_checker.sv
// Port-level checks for the console serial line register block.
`include "console_serial_line_registers_core_assert.svh"

module cslr_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input cslr_pkg::t_in_word  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input cslr_pkg::t_out_word o_out_data,
    input logic                i_cfg_we,
    input logic [7:0]          i_cfg_data
);
    import cslr_pkg::*;

    `CSLR_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
    `CSLR_ASSERT(a_tx_char_idle, o_out_valid && !o_out_data.tx_valid |-> o_out_data.tx_char == 7'd0)
    `CSLR_ASSERT(a_tx_irq_emit, o_out_valid && o_out_data.tx_irq |-> o_out_data.tx_valid)
    `CSLR_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_out_valid && !o_in_stall)

endmodule

bind console_serial_line_registers_core cslr_checker u_cslr_checker (.*);

### sim/tb_console_serial_line_registers_core.sv
// Self-checking testbench of the console serial line register block.
module tb_console_serial_line_registers_core;
    import cslr_pkg::*;

    // Scoreboard: keep a private copy of the four registers, the tick
    // counter and the delay, and queue the result word each input word causes.
    class line_unit_scoreboard;
        logic [15:0] rx_status;
        logic [15:0] tx_status;
        logic [7:0]  rx_buffer;
        logic [7:0]  tx_buffer;
        logic [7:0]  tx_wait;
        logic [7:0]  tx_delay;
        t_out_word   awaited[$];
        int          errors;

        function new();
            rx_status = '0;
            tx_status = '0;
            tx_status[BIT_DONE] = 1'b1;
            rx_buffer = '0;
            tx_buffer = '0;
            tx_wait   = '0;
            tx_delay  = TX_DELAY_RESET;
            errors    = 0;
        endfunction

        function void set_delay(logic [7:0] value);
            tx_delay = value;
        endfunction

        // Advance the register copy by one accepted input word.
        function void take_word(t_in_word w);
            t_out_word  r;
            t_sel       sel;
            logic [7:0] lim;
            r = '0;
            sel = t_sel'(w.reg_offset[2:1]);
            case (w.mode)
                MODE_READ: begin
                    case (sel)
                        REG_RXS: r.read_data = rx_status;
                        REG_RXB: begin
                            // Hand out the buffer only once per received character.
                            if (rx_status[BIT_DONE]) begin
                                rx_status[BIT_DONE] = 1'b0;
                                rx_status[0] = 1'b0;
                                r.read_data = {8'h00, rx_buffer};
                            end
                        end
                        REG_TXS: r.read_data = tx_status;
                        default: ;
                    endcase
                end
                MODE_WRITE: begin
                    case (sel)
                        REG_RXS: rx_status[BIT_IE] = w.write_data[BIT_IE];
                        REG_RXB: r.bad_access = 1'b1;
                        REG_TXS: tx_status[BIT_IE] = w.write_data[BIT_IE];
                        default: begin
                            tx_buffer = w.write_data[7:0];
                            tx_status[BIT_DONE] = 1'b0;
                            tx_wait = '0;
                        end
                    endcase
                end
                MODE_RECV: begin
                    if (w.rx_char == CH_STAR)
                        rx_buffer = CH_STAR_MAP;
                    else if (w.rx_char == CH_DC3)
                        rx_buffer = CH_DC3_MAP;
                    else
                        rx_buffer = w.rx_char;
                    rx_status[BIT_DONE] = 1'b1;
                    r.rx_irq = rx_status[BIT_IE];
                end
                default: begin
                    // Count ticks only while a character is pending.
                    if (!tx_status[BIT_DONE]) begin
                        lim = (tx_delay > TX_DELAY_MAX) ? TX_DELAY_MAX : tx_delay;
                        if (tx_wait < TX_WAIT_MAX)
                            tx_wait = tx_wait + 8'd1;
                        if (tx_wait > lim) begin
                            r.tx_valid = 1'b1;
                            r.tx_char  = tx_buffer[6:0];
                            tx_status[BIT_DONE] = 1'b1;
                            r.tx_irq = tx_status[BIT_IE];
                        end
                    end
                end
            endcase
            awaited.push_back(r);
        endfunction

        function void note_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare a result word with the oldest queued expectation.
        function void match_result(t_out_word got);
            t_out_word want;
            if (awaited.size() == 0) begin
                $display("%0t: result word %h with none expected", $time, got);
                errors++;
                return;
            end
            want = awaited.pop_front();
            note_field("read_data", want.read_data, got.read_data);
            note_field("tx_valid", 16'(want.tx_valid), 16'(got.tx_valid));
            note_field("tx_char", 16'(want.tx_char), 16'(got.tx_char));
            note_field("rx_irq", 16'(want.rx_irq), 16'(got.rx_irq));
            note_field("tx_irq", 16'(want.tx_irq), 16'(got.tx_irq));
            note_field("bad_access", 16'(want.bad_access), 16'(got.bad_access));
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_word   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_word  o_out_data;
    logic       i_cfg_we;
    logic [7:0] i_cfg_data;

    line_unit_scoreboard sb = new();
    int                  burst_left;

    console_serial_line_registers_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Sample both handshakes on the edge itself; all drivers use nonblocking
    // updates, so the values seen here are the ones the block sees.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.take_word(i_in_data);
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            sb.match_result(o_out_data);
    end

    function automatic t_in_word word_of(t_mode m, logic [2:0] off, logic [15:0] wd,
                                         logic [7:0] ch);
        t_in_word w;
        w.mode       = m;
        w.reg_offset = off;
        w.write_data = wd;
        w.rx_char    = ch;
        return w;
    endfunction

    // Build a random word; every field is randomized, used or not.
    function automatic t_in_word random_word(int tick_pct, bit allow_txb);
        t_in_word w;
        w.reg_offset = 3'($urandom_range(0, 7));
        w.write_data = 16'($urandom);
        w.rx_char    = 8'($urandom);
        if ($urandom_range(0, 99) < tick_pct) begin
            w.mode = MODE_TICK;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: w.mode = MODE_READ;
                4, 5, 6:    w.mode = MODE_WRITE;
                default:    w.mode = MODE_RECV;
            endcase
        end
        // Keep a long tick run from being restarted by a buffer write.
        if (w.mode == MODE_WRITE && !allow_txb && w.reg_offset[2:1] == REG_TXB)
            w.reg_offset[2:1] = REG_TXS;
        if (w.mode == MODE_RECV) begin
            case ($urandom_range(0, 7))
                0:       w.rx_char = CH_STAR;
                1:       w.rx_char = CH_DC3;
                default: ;
            endcase
        end
        return w;
    endfunction

    // Offer one word and return on the edge that takes it. Insert a random
    // gap between bursts; hold the payload steady while stalled.
    task automatic offer_word(input t_in_word w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 5))
                0, 1:    gap = 0;
                2, 3, 4: gap = $urandom_range(1, 4);
                default: gap = $urandom_range(8, 30);
            endcase
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Drop valid, wait until every result is back, let the pipeline settle,
    // then write the delay register.
    task automatic program_delay(input logic [7:0] value);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.awaited.size() != 0);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        sb.set_delay(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_run(input int count, input int tick_pct, input bit allow_txb);
        repeat (count) offer_word(random_word(tick_pct, allow_txb));
    endtask

    // Receiver: stall in segments of none, light or heavy pressure, and
    // every sixth segment hold off long enough for the input side to back up.
    initial begin
        int seg;
        int span;
        int level;
        seg = 0;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            seg++;
            if (seg % 6 == 3) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(60, 120)) @(posedge i_clk);
            end else begin
                span = $urandom_range(10, 80);
                case ($urandom_range(0, 2))
                    0:       level = 0;
                    1:       level = 25;
                    default: level = 70;
                endcase
                repeat (span) begin
                    i_out_stall <= ($urandom_range(0, 99) < level);
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        int drain_cycles;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_data  <= '0;
        burst_left  = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset values, the bad write, remaps, overwrite while done,
        // interrupt enables and a tick while ready, at the reset delay.
        offer_word(word_of(MODE_READ,  {REG_RXS, 1'b0}, 16'h0000, 8'h00));
        offer_word(word_of(MODE_READ,  {REG_RXB, 1'b0}, 16'hffff, 8'hff));
        offer_word(word_of(MODE_READ,  {REG_TXS, 1'b1}, 16'h0000, 8'h00));
        offer_word(word_of(MODE_READ,  {REG_TXB, 1'b1}, 16'h0000, 8'h00));
        offer_word(word_of(MODE_WRITE, {REG_RXB, 1'b1}, 16'hffff, 8'hff));
        offer_word(word_of(MODE_WRITE, {REG_RXS, 1'b0}, 16'hffff, 8'h00));
        offer_word(word_of(MODE_READ,  {REG_RXS, 1'b0}, 16'h0000, 8'h00));
        offer_word(word_of(MODE_RECV,  {REG_RXS, 1'b0}, 16'h0000, CH_STAR));
        offer_word(word_of(MODE_READ,  {REG_RXS, 1'b1}, 16'h0000, 8'h00));
        offer_word(word_of(MODE_READ,  {REG_RXB, 1'b0}, 16'h0000, 8'h00));
        offer_word(word_of(MODE_RECV,  {REG_TXB, 1'b1}, 16'hffff, CH_DC3));
        offer_word(word_of(MODE_RECV,  {REG_RXS, 1'b0}, 16'h0000, 8'hff));
        offer_word(word_of(MODE_READ,  {REG_RXB, 1'b1}, 16'h0000, 8'h00));
        offer_word(word_of(MODE_WRITE, {REG_RXS, 1'b0}, 16'hffbf, 8'h00));
        offer_word(word_of(MODE_RECV,  {REG_RXS, 1'b0}, 16'h0000, 8'h00));
        offer_word(word_of(MODE_WRITE, {REG_TXS, 1'b0}, 16'h0040, 8'h00));
        offer_word(word_of(MODE_TICK,  {REG_RXS, 1'b0}, 16'h0000, 8'h00));
        random_run(80, 70, 1'b1);

        // Zero delay: emit on the first tick, with the interrupt enable as left and then cleared.
        program_delay(8'd0);
        offer_word(word_of(MODE_WRITE, {REG_TXB, 1'b0}, 16'hffff, 8'h00));
        offer_word(word_of(MODE_READ,  {REG_TXS, 1'b0}, 16'h0000, 8'h00));
        offer_word(word_of(MODE_TICK,  {REG_RXS, 1'b0}, 16'h0000, 8'h00));
        offer_word(word_of(MODE_TICK,  {REG_RXS, 1'b0}, 16'h0000, 8'h00));
        offer_word(word_of(MODE_WRITE, {REG_TXS, 1'b1}, 16'h0000, 8'h00));
        offer_word(word_of(MODE_WRITE, {REG_TXB, 1'b1}, 16'h0080, 8'h00));
        offer_word(word_of(MODE_TICK,  {REG_RXS, 1'b0}, 16'h0000, 8'h00));
        offer_word(word_of(MODE_WRITE, {REG_TXB, 1'b0}, 16'h0055, 8'h00));
        offer_word(word_of(MODE_TICK,  {REG_RXS, 1'b0}, 16'h0000, 8'h00));
        random_run(80, 30, 1'b1);

        // Largest delay: one buffer write, then a long tick-heavy run.
        program_delay(TX_DELAY_MAX);
        offer_word(word_of(MODE_WRITE, {REG_TXB, 1'b0}, 16'(16'($urandom)), 8'h00));
        random_run(300, 97, 1'b0);

        program_delay(8'($urandom_range(1, 16)));
        random_run(80, 40, 1'b1);

        // Out-of-range delay acts as the largest one; it must still emit.
        program_delay(8'hff);
        offer_word(word_of(MODE_WRITE, {REG_TXB, 1'b1}, 16'(16'($urandom)), 8'h00));
        random_run(300, 97, 1'b0);

        program_delay(8'($urandom_range(0, 254)));
        random_run(60, 60, 1'b1);

        // Drain every expected result, then keep clocking the pipeline so that any
        // stray word shows.
        i_in_valid <= 1'b0;
        drain_cycles = 0;
        do begin
            @(posedge i_clk);
            drain_cycles++;
        end while (sb.awaited.size() != 0 && drain_cycles < 20000);
        repeat (8) @(posedge i_clk);
        if (sb.awaited.size() != 0) begin
            $display("%0t: %0d result words never arrived", $time, sb.awaited.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
